>>> src/k_way_sorted_merge_unit_assert.svh
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit_assert.svh
// Assertion macros shared by the merge unit.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_UNIT_ASSERT_SVH
`define K_WAY_SORTED_MERGE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define KWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge unit check failed");

// Next-cycle implication, checked out of reset
`define KWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge unit check failed");

`endif

>>> src/kwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, status codes and control structs of the merge unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

    // Sizing
    localparam int MAX_STREAMS = 8;
    localparam int VALUE_BITS  = 32;
    localparam int STR_W       = $clog2(MAX_STREAMS);
    localparam int SCNT_W      = $clog2(MAX_STREAMS + 1);

    // Fixed field widths of the ports
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 3;
    localparam int CFG_W   = 4;
    localparam int TOTAL_W = 32;

    // Request codes
    localparam logic REQ_VALUE = 1'b0;
    localparam logic REQ_END   = 1'b1;

    // Per-stream status codes
    localparam logic [1:0] ST_AWAIT = 2'd0;
    localparam logic [1:0] ST_HOLD  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic apply_item;
        logic emit_done;
        logic scan_start;
        logic scan_step;
        logic emit_value;
    } kwm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic any_await;
        logic any_hold;
        logic scan_last;
        logic out_free;
    } kwm_sts_t;

endpackage : kwm_pkg
`default_nettype wire

>>> src/kwm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer of the merge unit: takes a beat, checks stream status, runs the
// minimum scan and hands results to the output register.
// ----------------------------------------------------------------------------
module kwm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire kwm_pkg::kwm_sts_t sts,
    output kwm_pkg::kwm_cmd_t      cmd
);
    import kwm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.apply_item = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.any_await)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.any_hold)
                begin
                    // every stream in use ended: done result
                    if (sts.out_free)
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_value = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule : kwm_ctrl
`default_nettype wire

>>> src/kwm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_datapath
// Head and status registers, emission counter, sequential minimum scan and
// the output register of the merge unit.
// ----------------------------------------------------------------------------
module kwm_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [kwm_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire logic                                req_type,
    input  wire logic [kwm_pkg::INDEX_W-1:0]         stream_index,
    input  wire logic signed [kwm_pkg::VALUE_W-1:0]  incoming_value,
    input  wire kwm_pkg::kwm_cmd_t                   cmd,
    output kwm_pkg::kwm_sts_t                        sts,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic signed [kwm_pkg::VALUE_W-1:0]       merged_value,
    output logic [kwm_pkg::INDEX_W-1:0]              source_stream,
    output logic                                     merge_done,
    output logic [kwm_pkg::TOTAL_W-1:0]              emitted_total
);
    import kwm_pkg::*;

    // Stream state
    logic [1:0]                   status_reg  [MAX_STREAMS];
    logic [1:0]                   status_next [MAX_STREAMS];
    logic signed [VALUE_BITS-1:0] head_reg    [MAX_STREAMS];
    logic signed [VALUE_BITS-1:0] head_next   [MAX_STREAMS];
    logic [TOTAL_W-1:0]           cnt_reg;
    logic [TOTAL_W-1:0]           cnt_next;
    logic [CFG_W-1:0]             active_reg;

    // Scan state
    logic [STR_W-1:0]             scan_idx_reg;
    logic [STR_W-1:0]             scan_idx_next;
    logic [STR_W-1:0]             best_idx_reg;
    logic [STR_W-1:0]             best_idx_next;
    logic signed [VALUE_BITS-1:0] best_val_reg;
    logic signed [VALUE_BITS-1:0] best_val_next;
    logic                         found_reg;
    logic                         found_next;

    // Output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [VALUE_W-1:0]    merged_value_reg;
    logic signed [VALUE_W-1:0]    merged_value_next;
    logic [INDEX_W-1:0]           source_stream_reg;
    logic [INDEX_W-1:0]           source_stream_next;
    logic                         merge_done_reg;
    logic                         merge_done_next;
    logic [TOTAL_W-1:0]           emitted_total_reg;
    logic [TOTAL_W-1:0]           emitted_total_next;

    logic [SCNT_W-1:0]            stream_cnt;
    logic [STR_W-1:0]             item_idx;
    logic                         item_in_range;
    logic                         any_await;
    logic                         any_hold;
    logic signed [VALUE_BITS-1:0] cand_val;
    logic                         cand_hold;
    logic [TOTAL_W-1:0]           cnt_inc;
    logic                         out_free;

    // Effective stream count: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (active_reg == '0)
        begin
            stream_cnt = SCNT_W'(1);
        end
        else if (int'(active_reg) > MAX_STREAMS)
        begin
            stream_cnt = SCNT_W'(MAX_STREAMS);
        end
        else
        begin
            stream_cnt = SCNT_W'(active_reg);
        end
    end

    assign item_idx      = STR_W'(stream_index);
    assign item_in_range = (int'(stream_index) < int'(stream_cnt));

    // Status summary over the streams in the merge
    always_comb
    begin
        any_await = 1'b0;
        any_hold  = 1'b0;
        for (int i = 0; i < MAX_STREAMS; i++)
        begin
            if (i < int'(stream_cnt))
            begin
                if (status_reg[i] == ST_AWAIT)
                begin
                    any_await = 1'b1;
                end
                if (status_reg[i] == ST_HOLD)
                begin
                    any_hold = 1'b1;
                end
            end
        end
    end

    assign cand_val  = head_reg[scan_idx_reg];
    assign cand_hold = (status_reg[scan_idx_reg] == ST_HOLD);
    assign cnt_inc   = (cnt_reg == '1) ? cnt_reg : cnt_reg + TOTAL_W'(1);
    assign out_free  = !out_valid_reg || !out_stall;

    assign sts.any_await = any_await;
    assign sts.any_hold  = any_hold;
    assign sts.scan_last = (int'(scan_idx_reg) == int'(stream_cnt) - 1);
    assign sts.out_free  = out_free;

    // Stream state updates
    always_comb
    begin
        status_next = status_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        if (cmd.apply_item && item_in_range && status_reg[item_idx] == ST_AWAIT)
        begin
            if (req_type == REQ_VALUE)
            begin
                head_next[item_idx]   = VALUE_BITS'(incoming_value);
                status_next[item_idx] = ST_HOLD;
            end
            else
            begin
                status_next[item_idx] = ST_END;
            end
        end
        if (cmd.emit_done)
        begin
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                status_next[i] = ST_AWAIT;
            end
            cnt_next = '0;
        end
        if (cmd.emit_value)
        begin
            status_next[best_idx_reg] = ST_AWAIT;
            cnt_next                  = cnt_inc;
        end
    end

    // Minimum scan, one stream a cycle; ties go to the later stream
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        found_next    = found_reg;
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            found_next    = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (cand_hold && (!found_reg || cand_val <= best_val_reg))
            begin
                best_idx_next = scan_idx_reg;
                best_val_next = cand_val;
                found_next    = 1'b1;
            end
            scan_idx_next = scan_idx_reg + STR_W'(1);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next     = out_valid_reg && out_stall;
        merged_value_next  = merged_value_reg;
        source_stream_next = source_stream_reg;
        merge_done_next    = merge_done_reg;
        emitted_total_next = emitted_total_reg;
        if (cmd.emit_done)
        begin
            out_valid_next     = 1'b1;
            merged_value_next  = '0;
            source_stream_next = '0;
            merge_done_next    = 1'b1;
            emitted_total_next = cnt_reg;
        end
        else if (cmd.emit_value)
        begin
            out_valid_next     = 1'b1;
            merged_value_next  = VALUE_W'(best_val_reg);
            source_stream_next = INDEX_W'(best_idx_reg);
            merge_done_next    = 1'b0;
            emitted_total_next = cnt_inc;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                status_reg[i] <= ST_AWAIT;
            end
            cnt_reg       <= '0;
            active_reg    <= CFG_W'(MAX_STREAMS);
            found_reg     <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                active_reg <= cfg_wr_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        head_reg          <= head_next;
        best_idx_reg      <= best_idx_next;
        best_val_reg      <= best_val_next;
        merged_value_reg  <= merged_value_next;
        source_stream_reg <= source_stream_next;
        merge_done_reg    <= merge_done_next;
        emitted_total_reg <= emitted_total_next;
    end

    assign out_valid     = out_valid_reg;
    assign merged_value  = merged_value_reg;
    assign source_stream = source_stream_reg;
    assign merge_done    = merge_done_reg;
    assign emitted_total = emitted_total_reg;

endmodule : kwm_datapath
`default_nettype wire

>>> src/k_way_sorted_merge_unit.sv
// An item that leaves some stream awaiting gives no beat.
// A done result is registered from the check state once the output is free; a merged value
// after the minimum scan over the N streams in use, one stream a cycle, once the output is free.
// One item at a time; in_stall is high from acceptance until the item is finished.
// Reset: all streams awaiting, count zero, stream count 8, output empty.
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit
// Merges up to eight ascending integer streams into one ascending stream.
// ----------------------------------------------------------------------------
`include "k_way_sorted_merge_unit_assert.svh"

module k_way_sorted_merge_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [kwm_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                req_type,
    input  wire logic [kwm_pkg::INDEX_W-1:0]         stream_index,
    input  wire logic signed [kwm_pkg::VALUE_W-1:0]  incoming_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [kwm_pkg::VALUE_W-1:0]       merged_value,
    output logic [kwm_pkg::INDEX_W-1:0]              source_stream,
    output logic                                     merge_done,
    output logic [kwm_pkg::TOTAL_W-1:0]              emitted_total
);
    import kwm_pkg::*;

    kwm_cmd_t cmd;
    kwm_sts_t sts;

    // Sequencer
    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    kwm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_type       (req_type),
        .stream_index   (stream_index),
        .incoming_value (incoming_value),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .merged_value   (merged_value),
        .source_stream  (source_stream),
        .merge_done     (merge_done),
        .emitted_total  (emitted_total)
    );

    // Checks
    `KWM_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
    `KWM_ASSERT_NOW(a_done_payload, out_valid && merge_done,
                    merged_value == '0 && source_stream == '0)
    `KWM_ASSERT_NOW(a_value_counted, out_valid && !merge_done, emitted_total != '0)
    `KWM_ASSERT_NOW(a_one_command, 1'b1, $onehot0(cmd))

endmodule : k_way_sorted_merge_unit
`default_nettype wire

>>> test/tb_k_way_sorted_merge_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_k_way_sorted_merge_unit
// Self-checking bench for the k-way merge unit. Requests are queued by the
// stimulus process and presented by a clocked driver. Each accepted request
// is run through a behavioural merge model, and its result beat, if any,
// is queued. A clocked monitor then checks every output beat against the
// oldest queued one. Both sides idle at random, and the stream count is
// changed between phases, including while a merge is still open.
// ----------------------------------------------------------------------------
module tb_k_way_sorted_merge_unit;
    import kwm_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE       = 16;

    // One request beat as presented to the block
    typedef struct packed {
        logic        kind;
        logic [2:0]  idx;
        logic [31:0] value;
    } merge_req_t;

    // One result beat
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         src;
        logic               done;
        logic [31:0]        total;
    } merge_beat_t;

    // Merge state: heads, per-stream status, emission count, stream count
    typedef struct packed {
        logic [7:0][31:0] head;
        logic [7:0][1:0]  status;
        logic [31:0]      emitted;
        logic [3:0]       streams_cfg;
    } merge_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_VALUE;
    logic [2:0]  stream_index = '0;
    logic signed [31:0] incoming_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] merged_value;
    logic [2:0]  source_stream;
    logic        merge_done;
    logic [31:0] emitted_total;

    merge_req_t  queued_reqs[$];
    merge_beat_t expected_merges[$];

    merge_state_t plan_st;     // state as the stimulus will leave it
    merge_state_t live_st;     // state after the requests accepted so far
    logic signed [31:0] plan_last[8];

    int idle_pct = 11;
    int planned_applied = 0;
    int accepted_cnt = 0;
    int acc_seen = 0;
    int ignored_cnt = 0;
    int value_beats = 0;
    int done_beats = 0;
    int fails = 0;
    int cycles = 0;

    merge_beat_t beat_now;
    merge_beat_t want;
    bit          took_now;
    merge_req_t  drv_req;

    k_way_sorted_merge_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .stream_index   (stream_index),
        .incoming_value (incoming_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .merged_value   (merged_value),
        .source_stream  (source_stream),
        .merge_done     (merge_done),
        .emitted_total  (emitted_total)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Out-of-range counts are clamped to 1 .. MAX_STREAMS
    function automatic int streams_in_use(input logic [3:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > MAX_STREAMS)
            return MAX_STREAMS;
        return cfg;
    endfunction

    // Applies one request and returns 1 if it yields a result beat
    function automatic bit merge_step(inout merge_state_t s, input logic kind,
                                      input logic [2:0] idx, input logic [31:0] val,
                                      output merge_beat_t res, output bit took);
        int  n;
        int  i;
        int  best;
        bit  any_hold;
        n        = streams_in_use(s.streams_cfg);
        res      = '0;
        best     = 0;
        any_hold = 1'b0;
        took     = (idx < n) && (s.status[idx] == ST_AWAIT);
        if (took)
        begin
            if (kind == REQ_VALUE)
            begin
                s.head[idx]   = val;
                s.status[idx] = ST_HOLD;
            end
            else
                s.status[idx] = ST_END;
        end
        // pick the smallest head, highest index wins a tie
        for (i = 0; i < n; i++)
        begin
            if (s.status[i] == ST_AWAIT)
                return 1'b0;
            if (s.status[i] == ST_HOLD &&
                (!any_hold || $signed(s.head[i]) <= $signed(s.head[best])))
            begin
                best     = i;
                any_hold = 1'b1;
            end
        end
        if (!any_hold)
        begin
            res.done  = 1'b1;
            res.total = s.emitted;
            for (i = 0; i < MAX_STREAMS; i++)
                s.status[i] = ST_AWAIT;
            s.emitted = '0;
            return 1'b1;
        end
        if (s.emitted != '1)
            s.emitted = s.emitted + 1;
        res.value      = s.head[best];
        res.src        = best[2:0];
        res.total      = s.emitted;
        s.status[best] = ST_AWAIT;
        return 1'b1;
    endfunction

    // Queue one request and advance the planning state
    task automatic put(input logic kind, input logic [2:0] idx, input logic [31:0] val);
        merge_beat_t scratch;
        bit          took;
        void'(merge_step(plan_st, kind, idx, val, scratch, took));
        if (took)
            planned_applied++;
        queued_reqs.push_back('{kind: kind, idx: idx, value: val});
    endtask

    // Random requests: mostly the next beat of an awaiting stream, some noise
    task automatic feed(input int count);
        int stop_at;
        int n;
        int i;
        int pick;
        int r;
        int open_streams[$];
        stop_at = planned_applied + count;
        while (planned_applied < stop_at)
        begin
            n = streams_in_use(plan_st.streams_cfg);
            open_streams.delete();
            for (i = 0; i < n; i++)
                if (plan_st.status[i] == ST_AWAIT)
                    open_streams.push_back(i);
            if (open_streams.size() == 0 || $urandom_range(0, 99) < 12)
                put($urandom_range(0, 1), $urandom_range(0, 7), $urandom);
            else
            begin
                pick = open_streams[$urandom_range(0, open_streams.size() - 1)];
                r    = $urandom_range(0, 99);
                if (r < 10)
                    put(REQ_END, pick, $urandom);
                else
                begin
                    if (r < 24)
                        plan_last[pick] = $urandom;
                    else if (r < 38)
                        plan_last[pick] = $signed($urandom_range(0, 16)) - 8;
                    else if (plan_last[pick] < 32'sh7FFF_FFF0)
                        plan_last[pick] = plan_last[pick] + $urandom_range(0, 3);
                    put(REQ_VALUE, pick, plan_last[pick]);
                end
            end
        end
    endtask

    // Wait for every queued request to go in and every beat to come out
    task automatic settle_idle(input int extra);
        while (queued_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_merges.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Stream-count write, only with the block idle
    task automatic set_streams(input logic [3:0] cnt);
        settle_idle(SETTLE);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        plan_st.streams_cfg = cnt;
        live_st.streams_cfg = cnt;
    endtask

    // Request driver: new beat only when the line is free or was just taken
    always @(negedge clk)
    begin
        acc_seen <= accepted_cnt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || accepted_cnt != acc_seen)
        begin
            if (queued_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                drv_req = queued_reqs.pop_front();
                req_type       <= drv_req.kind;
                stream_index   <= drv_req.idx;
                incoming_value <= drv_req.value;
                in_valid       <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < idle_pct);

    // Accepted requests go through the model
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            accepted_cnt <= accepted_cnt + 1;
            if (merge_step(live_st, req_type, stream_index, incoming_value,
                           beat_now, took_now))
                expected_merges.push_back(beat_now);
            if (!took_now)
                ignored_cnt++;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_merges.size() == 0)
            begin
                $error("result beat with nothing expected: value %0d stream %0d done %0b",
                       merged_value, source_stream, merge_done);
                fails++;
            end
            else
            begin
                want = expected_merges.pop_front();
                if (want.done)
                    done_beats++;
                else
                    value_beats++;
                if (merged_value !== want.value)
                begin
                    $error("merged_value: expected %0d, got %0d", want.value, merged_value);
                    fails++;
                end
                if (source_stream !== want.src)
                begin
                    $error("source_stream: expected %0d, got %0d", want.src, source_stream);
                    fails++;
                end
                if (merge_done !== want.done)
                begin
                    $error("merge_done: expected %0b, got %0b", want.done, merge_done);
                    fails++;
                end
                if (emitted_total !== want.total)
                begin
                    $error("emitted_total: expected %0d, got %0d", want.total, emitted_total);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb_k_way_sorted_merge_unit: errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        plan_st = '0;
        plan_st.streams_cfg = 4'd8;
        live_st = plan_st;
        for (int i = 0; i < 8; i++)
            plan_last[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, ties resolved to the highest index, beats for held streams
        put(REQ_VALUE, 3'd0, 32'h7FFF_FFFF);
        put(REQ_VALUE, 3'd7, 32'h8000_0000);
        put(REQ_VALUE, 3'd1, 32'hFFFF_FFFF);
        put(REQ_VALUE, 3'd2, 32'd5);
        put(REQ_VALUE, 3'd3, 32'd5);
        put(REQ_VALUE, 3'd4, 32'd0);
        put(REQ_VALUE, 3'd5, 32'd5);
        put(REQ_VALUE, 3'd6, 32'd5);
        put(REQ_VALUE, 3'd0, 32'd1);
        put(REQ_END,   3'd7, 32'd0);
        put(REQ_END,   3'd1, 32'd0);
        put(REQ_VALUE, 3'd4, 32'd5);
        put(REQ_END,   3'd7, 32'd0);
        put(REQ_END,   3'd6, 32'd0);

        // shrink the merge while it is open: an ignored beat can then emit
        set_streams(4'd2);
        put(REQ_VALUE, 3'd5, 32'd9);
        put(REQ_END,   3'd0, 32'd0);

        // zero acts as a single stream; indices past the count are ignored
        set_streams(4'd0);
        put(REQ_VALUE, 3'd0, 32'hFFFF_FFFB);
        put(REQ_VALUE, 3'd7, 32'h1234_5678);
        put(REQ_VALUE, 3'd0, 32'h8000_0000);
        put(REQ_END,   3'd0, 32'd0);

        // counts above the maximum act as the maximum
        set_streams(4'd15);
        feed(300);
        set_streams(4'd1);
        feed(150);

        // a long stretch with no idling on either side
        set_streams(4'd3);
        idle_pct = 0;
        feed(150);
        settle_idle(0);
        feed(150);
        idle_pct = 11;

        set_streams(4'd8);
        feed(400);
        set_streams(4'd5);
        feed(250);
        set_streams(4'd12);
        feed(250);

        settle_idle(30);
        $display("%0d requests accepted (%0d ignored), stream counts 0 to 15", accepted_cnt,
                 ignored_cnt);
        $display("%0d merged values and %0d done beats checked", value_beats, done_beats);
        if (fails == 0)
            $display("tb_k_way_sorted_merge_unit: clean");
        else
            $display("tb_k_way_sorted_merge_unit: errors");
        $finish;
    end

endmodule

>>> k_way_sorted_merge_unit.f
+incdir+src
src/kwm_pkg.sv
src/kwm_ctrl.sv
src/kwm_datapath.sv
src/k_way_sorted_merge_unit.sv
test/tb_k_way_sorted_merge_unit.sv
